// ===== src/tkm_pkg.sv =====
// Shared constants, codes and types of the trie keyword matcher.
`timescale 1ns / 1ps
`default_nettype none
package tkm_pkg;

  localparam int NODE_COUNT = 256;
  localparam int ALPHABET   = 26;
  localparam int SYM_W      = 5;

  localparam logic [7:0] LOW_A  = 8'd97;
  localparam logic [7:0] HIGH_Z = 8'd122;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_LOOKUP   = 2'd0,
    ST_INSERTED = 2'd1,
    ST_INVALID  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LINK,
    S_MARK
  } walk_state_t;

endpackage
`default_nettype wire

// ===== src/tkm_in_if.sv =====
// Character channel of the trie keyword matcher.
`timescale 1ns / 1ps
`default_nettype none
interface tkm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] letter;
  logic       last;

  modport source (output valid, output cmd, output letter, output last, input ready);
  modport sink (input valid, input cmd, input letter, input last, output ready);
endinterface
`default_nettype wire

// ===== src/tkm_out_if.sv =====
// Result channel of the trie keyword matcher.
`timescale 1ns / 1ps
`default_nettype none
interface tkm_out_if;
  logic       valid;
  logic       ready;
  logic       kw_hit;
  logic [1:0] status;

  modport source (output valid, output kw_hit, output status, input ready);
  modport sink (input valid, input kw_hit, input status, output ready);
endinterface
`default_nettype wire

// ===== src/trie_keyword_matcher.sv =====
// A character that is not the last of its word is taken in S_IDLE; its child link is read
// and written back in S_LINK, and only then is the next character taken in S_IDLE.
// A last character also reads its end mark in S_LINK and writes its result in S_MARK into
// the output register, which waits while a previous result is not yet taken.
// Reset: synchronous, active low; afterwards a clearing pass over all NODE_COUNT * 26 link
// addresses zeroes the link and end-mark memories before the first word is taken.
`timescale 1ns / 1ps
`default_nettype none
module trie_keyword_matcher #(
  parameter int NODE_COUNT = tkm_pkg::NODE_COUNT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tkm_in_if.sink    in_ch,
  tkm_out_if.source out_ch
);

  localparam int NW         = $clog2(NODE_COUNT);
  localparam int LINK_DEPTH = NODE_COUNT * tkm_pkg::ALPHABET;
  localparam int LAW        = $clog2(LINK_DEPTH);

  logic           lk_we;
  logic [LAW-1:0] lk_waddr;
  logic [NW-1:0]  lk_wdata;
  logic           lk_re;
  logic [LAW-1:0] lk_raddr;
  logic [NW-1:0]  lk_rdata;
  logic           mk_we;
  logic [NW-1:0]  mk_waddr;
  logic           mk_wdata;
  logic           mk_re;
  logic [NW-1:0]  mk_raddr;
  logic           mk_rdata;

  tkm_ram #(
    .DEPTH (LINK_DEPTH),
    .WIDTH (NW)
  ) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  tkm_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (1)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mk_we),
    .waddr (mk_waddr),
    .wdata (mk_wdata),
    .re    (mk_re),
    .raddr (mk_raddr),
    .rdata (mk_rdata)
  );

  tkm_walker #(
    .NODE_COUNT (NODE_COUNT)
  ) u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .lk_we    (lk_we),
    .lk_waddr (lk_waddr),
    .lk_wdata (lk_wdata),
    .lk_re    (lk_re),
    .lk_raddr (lk_raddr),
    .lk_rdata (lk_rdata),
    .mk_we    (mk_we),
    .mk_waddr (mk_waddr),
    .mk_wdata (mk_wdata),
    .mk_re    (mk_re),
    .mk_raddr (mk_raddr),
    .mk_rdata (mk_rdata)
  );

endmodule
`default_nettype wire

// ===== src/tkm_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tkm_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/tkm_walker.sv =====
// Trie walker: clearing pass, link read-modify-write, end marks and result register.
`timescale 1ns / 1ps
`default_nettype none
module tkm_walker #(
  parameter int NODE_COUNT = tkm_pkg::NODE_COUNT,
  localparam int NW = $clog2(NODE_COUNT),
  localparam int LINK_DEPTH = NODE_COUNT * tkm_pkg::ALPHABET,
  localparam int LAW = $clog2(LINK_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  tkm_in_if.sink             in_ch,
  tkm_out_if.source          out_ch,
  output logic               lk_we,
  output logic [LAW-1:0]     lk_waddr,
  output logic [NW-1:0]      lk_wdata,
  output logic               lk_re,
  output logic [LAW-1:0]     lk_raddr,
  input  wire logic [NW-1:0] lk_rdata,
  output logic               mk_we,
  output logic [NW-1:0]      mk_waddr,
  output logic               mk_wdata,
  output logic               mk_re,
  output logic [NW-1:0]      mk_raddr,
  input  wire logic          mk_rdata
);

  localparam int FW = $clog2(NODE_COUNT + 1);

  tkm_pkg::walk_state_t state_r, state_nxt;
  logic [LAW-1:0]       clr_r, clr_nxt;
  logic [NW-1:0]        cursor_r, cursor_nxt;
  logic [FW-1:0]        free_r, free_nxt;
  logic                 failed_r, failed_nxt;
  tkm_pkg::status_t     code_r, code_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 cmd_r, cmd_nxt;
  logic                 last_r, last_nxt;
  logic                 bad_r, bad_nxt;
  logic [LAW-1:0]       addr_r, addr_nxt;
  logic                 out_kw_r, out_kw_nxt;
  tkm_pkg::status_t     out_status_r, out_status_nxt;

  logic [7:0]           sym_full;
  logic [LAW-1:0]       link_addr;
  logic                 letter_bad;
  logic [NW-1:0]        cur_w;

  assign sym_full   = in_ch.letter - tkm_pkg::LOW_A;
  assign letter_bad = (in_ch.letter < tkm_pkg::LOW_A) || (in_ch.letter > tkm_pkg::HIGH_Z);
  assign link_addr  = LAW'(cursor_r) * LAW'(tkm_pkg::ALPHABET)
                      + LAW'(sym_full[tkm_pkg::SYM_W-1:0]);

  assign out_ch.valid  = out_valid_r;
  assign out_ch.kw_hit = out_kw_r;
  assign out_ch.status = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cursor_nxt     = cursor_r;
    free_nxt       = free_r;
    failed_nxt     = failed_r;
    code_nxt       = code_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    cmd_nxt        = cmd_r;
    last_nxt       = last_r;
    bad_nxt        = bad_r;
    addr_nxt       = addr_r;
    out_kw_nxt     = out_kw_r;
    out_status_nxt = out_status_r;
    in_ch.ready    = 1'b0;
    lk_we          = 1'b0;
    lk_waddr       = addr_r;
    lk_wdata       = free_r[NW-1:0];
    lk_re          = 1'b0;
    lk_raddr       = link_addr;
    mk_we          = 1'b0;
    mk_waddr       = cursor_r;
    mk_wdata       = 1'b1;
    mk_re          = 1'b0;
    mk_raddr       = cursor_r;
    cur_w          = cursor_r;
    case (state_r)
      tkm_pkg::S_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = clr_r;
        lk_wdata = '0;
        mk_we    = 1'b1;
        mk_waddr = clr_r[NW-1:0];
        mk_wdata = 1'b0;
        clr_nxt  = clr_r + LAW'(1);
        if (clr_r == LAW'(LINK_DEPTH - 1)) begin
          state_nxt = tkm_pkg::S_IDLE;
        end
      end
      tkm_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          last_nxt  = in_ch.last;
          bad_nxt   = letter_bad;
          addr_nxt  = link_addr;
          lk_re     = 1'b1;
          state_nxt = tkm_pkg::S_LINK;
        end
      end
      tkm_pkg::S_LINK: begin
        if (!failed_r) begin
          if (bad_r) begin
            failed_nxt = 1'b1;
            code_nxt   = (cmd_r == tkm_pkg::CMD_LOOKUP) ? tkm_pkg::ST_LOOKUP
                                                        : tkm_pkg::ST_INVALID;
          end else if (lk_rdata != '0) begin
            cur_w = lk_rdata;
          end else if (cmd_r == tkm_pkg::CMD_LOOKUP) begin
            failed_nxt = 1'b1;
            code_nxt   = tkm_pkg::ST_LOOKUP;
          end else if (free_r == FW'(NODE_COUNT)) begin
            failed_nxt = 1'b1;
            code_nxt   = tkm_pkg::ST_FULL;
          end else begin
            lk_we    = 1'b1;
            cur_w    = free_r[NW-1:0];
            free_nxt = free_r + FW'(1);
          end
        end
        cursor_nxt = cur_w;
        mk_raddr   = cur_w;
        if (last_r) begin
          mk_re     = 1'b1;
          state_nxt = tkm_pkg::S_MARK;
        end else begin
          state_nxt = tkm_pkg::S_IDLE;
        end
      end
      tkm_pkg::S_MARK: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (failed_r) begin
            out_kw_nxt     = 1'b0;
            out_status_nxt = code_r;
          end else if (cmd_r == tkm_pkg::CMD_INSERT) begin
            mk_we          = 1'b1;
            out_kw_nxt     = 1'b0;
            out_status_nxt = tkm_pkg::ST_INSERTED;
          end else begin
            out_kw_nxt     = mk_rdata;
            out_status_nxt = tkm_pkg::ST_LOOKUP;
          end
          cursor_nxt = '0;
          failed_nxt = 1'b0;
          code_nxt   = tkm_pkg::ST_LOOKUP;
          state_nxt  = tkm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tkm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tkm_pkg::S_CLEAR;
      clr_r       <= '0;
      cursor_r    <= '0;
      free_r      <= FW'(1);
      failed_r    <= 1'b0;
      code_r      <= tkm_pkg::ST_LOOKUP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cursor_r    <= cursor_nxt;
      free_r      <= free_nxt;
      failed_r    <= failed_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    last_r       <= last_nxt;
    bad_r        <= bad_nxt;
    addr_r       <= addr_nxt;
    out_kw_r     <= out_kw_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FW'(NODE_COUNT))
    else $error("Node pool pointer ran past the node count.");

  a_free_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (free_r != $past(free_r)))
      |-> ($past(lk_we) && $past(state_r == tkm_pkg::S_LINK)))
    else $error("Node pool pointer moved without a new link being written.");

  a_alloc_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (lk_we && state_r == tkm_pkg::S_LINK)
      |-> (lk_rdata == '0 && free_r != FW'(NODE_COUNT) && !failed_r))
    else $error("A link was written over an existing child or with no free node.");

  a_word_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tkm_pkg::S_MARK && state_nxt == tkm_pkg::S_IDLE)
      |=> (cursor_r == '0 && !failed_r && out_valid_r))
    else $error("Word state was not returned to the root after a result.");
`endif

endmodule
`default_nettype wire
